// ----- src/pba_pkg.sv -----
// shared types, constants and helpers of the page block allocator
package pba_pkg;

	localparam int MAX_TENANTS = 8;
	localparam int MAX_PINS    = 10;
	localparam int MAX_PAGES   = 256;

	localparam int TID_W = $clog2(MAX_TENANTS);
	localparam int PIN_IW = $clog2(MAX_PINS);
	localparam int PIN_CW = $clog2(MAX_PINS + 1);
	localparam int PG_W = 9;
	localparam int EVC_W = 4;
	localparam int CFG_IDX_W = 2;

	// operation codes
	localparam logic [2:0] OP_FIND   = 3'd0;
	localparam logic [2:0] OP_TOUCH  = 3'd1;
	localparam logic [2:0] OP_PUT    = 3'd2;
	localparam logic [2:0] OP_ALLOC  = 3'd3;
	localparam logic [2:0] OP_PIN    = 3'd4;
	localparam logic [2:0] OP_UNPIN  = 3'd5;
	localparam logic [2:0] OP_READ   = 3'd6;
	localparam logic [2:0] OP_FORMAT = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAGES   = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic scan_init;
		logic scan_step;
		logic evict_init;
		logic evict_step;
		logic evict_apply;
		logic fin_ok;
		logic out_load;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_alloc;
		logic alloc_bad;
		logic scan_hit;
		logic scan_end;
		logic evict_last;
		logic have_victim;
	} dp_status_t;

	// page index of a byte address within the region
	function automatic logic [31:0] page_index(input logic [31:0] addr,
		input logic [31:0] base, input logic [4:0] sh);
		page_index = (addr - base) >> sh;
	endfunction

endpackage

// ----- src/pba_ctrl.sv -----
// sequencing state machine of the page block allocator
module pba_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  pba_pkg::dp_status_t    st,
	output pba_pkg::ctrl_cmd_t     cmd
);
	import pba_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_EVICT = 6'b001000,
		S_APPLY = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!st.is_alloc) begin
					cmd.exec = 1'b1;
					state_d = S_DONE;
				end else if (st.alloc_bad) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.scan_hit) begin
					cmd.fin_ok = 1'b1;
					state_d = S_DONE;
				end else if (st.scan_end) begin
					cmd.evict_init = 1'b1;
					state_d = S_EVICT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_EVICT: begin
				cmd.evict_step = 1'b1;
				if (st.evict_last) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.evict_apply = 1'b1;
				if (st.have_victim) begin
					cmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC)
		else $error("accepted word not executed");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> state_q == S_IDLE && out_valid_q)
		else $error("finished word not presented");
`endif

endmodule

// ----- src/pba_dp.sv -----
// directory, pin table, scan counters and result registers
module pba_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pba_pkg::ctrl_cmd_t     cmd,
	output pba_pkg::dp_status_t    st,
	input  logic                   cfg_wr,
	input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic [2:0]             operation,
	input  logic [2:0]             slot,
	input  logic [31:0]            key_crc,
	input  logic [31:0]            key_size,
	input  logic [31:0]            key_api,
	input  logic [31:0]            block_address,
	input  logic [8:0]             page_count,
	input  logic [31:0]            stamp_in,
	output logic                   status,
	output logic [2:0]             found_slot,
	output logic [31:0]            alloc_address,
	output logic                   entry_valid,
	output logic [31:0]            entry_crc,
	output logic [31:0]            entry_size,
	output logic [31:0]            entry_api,
	output logic [8:0]             entry_pages,
	output logic [31:0]            entry_stamp,
	output logic [3:0]             evicted_count
);
	import pba_pkg::*;

	// configuration
	logic [31:0] base_q;
	logic [4:0]  shift_q;
	logic [PG_W-1:0] total_q;

	// captured request
	logic [2:0]  op_q;
	logic [TID_W-1:0] slot_q;
	logic [31:0] crc_q, size_q, api_q, baddr_q, stin_q;
	logic [PG_W-1:0] pcnt_q;

	// directory and pin table
	logic [MAX_TENANTS-1:0] t_valid_q;
	logic [31:0] t_crc_q [MAX_TENANTS];
	logic [31:0] t_size_q [MAX_TENANTS];
	logic [31:0] t_api_q [MAX_TENANTS];
	logic [31:0] t_addr_q [MAX_TENANTS];
	logic [PG_W-1:0] t_pages_q [MAX_TENANTS];
	logic [31:0] t_stamp_q [MAX_TENANTS];
	logic [31:0] stamp_next_q;
	logic [31:0] pin_addr_q [MAX_PINS];
	logic [PG_W-1:0] pin_pages_q [MAX_PINS];
	logic [PIN_CW-1:0] pin_count_q;

	// scan and eviction state
	logic [PG_W-1:0] p_q, run_q;
	logic [TID_W-1:0] ev_idx_q, ev_victim_q;
	logic ev_have_q;
	logic [31:0] ev_best_q;

	// working result
	logic res_status_q, res_valid_q;
	logic [TID_W-1:0] res_slot_q;
	logic [31:0] res_addr_q, res_crc_q, res_size_q, res_api_q, res_stamp_q;
	logic [PG_W-1:0] res_pages_q;
	logic [EVC_W-1:0] res_evc_q;

	// output word
	logic out_status_q, out_valid_q;
	logic [TID_W-1:0] out_slot_q;
	logic [31:0] out_addr_q, out_crc_q, out_size_q, out_api_q, out_stamp_q;
	logic [PG_W-1:0] out_pages_q;
	logic [EVC_W-1:0] out_evc_q;

	logic [PG_W-1:0] n_pages, nrun, start;
	logic [31:0] t_p0 [MAX_TENANTS];
	logic [31:0] pin_p0 [MAX_PINS];
	logic busy, pinned, cand;
	logic [TID_W-1:0] rd_idx;
	logic [31:0] rd_p0;
	logic find_hit, free_hit, unpin_hit;
	logic [TID_W-1:0] find_idx, free_idx;
	logic [PIN_IW-1:0] unpin_idx, last_idx;
	logic [31:0] start_off;

	// usable page count
	assign n_pages = (total_q > PG_W'(MAX_PAGES)) ? PG_W'(MAX_PAGES) : total_q;

	// first page of each tenant and pinned block
	always_comb begin
		for (int i = 0; i < MAX_TENANTS; i++) begin
			t_p0[i] = page_index(t_addr_q[i], base_q, shift_q);
		end
		for (int j = 0; j < MAX_PINS; j++) begin
			pin_p0[j] = page_index(pin_addr_q[j], base_q, shift_q);
		end
	end

	// busy test of the scanned page
	always_comb begin
		busy = (p_q == '0);
		for (int i = 0; i < MAX_TENANTS; i++) begin
			if (t_valid_q[i] && {23'b0, p_q} >= t_p0[i]
				&& {24'b0, p_q} < ({1'b0, t_p0[i]} + {24'b0, t_pages_q[i]})) begin
				busy = 1'b1;
			end
		end
	end

	assign nrun = busy ? '0 : run_q + PG_W'(1);
	assign start = p_q - pcnt_q + PG_W'(1);
	assign start_off = {23'b0, start} << shift_q;

	// pin check of the tenant under eviction scan
	assign rd_idx = cmd.evict_step ? ev_idx_q : slot_q;
	assign rd_p0 = t_p0[rd_idx];
	always_comb begin
		pinned = 1'b0;
		for (int j = 0; j < MAX_PINS; j++) begin
			if (PIN_CW'(j) < pin_count_q && rd_p0 >= pin_p0[j]
				&& {1'b0, rd_p0} < ({1'b0, pin_p0[j]} + {24'b0, pin_pages_q[j]})) begin
				pinned = 1'b1;
			end
		end
	end
	assign cand = t_valid_q[rd_idx] && !pinned && (!ev_have_q || t_stamp_q[rd_idx] < ev_best_q);

	// lowest key match, lowest free slot, first matching pin
	always_comb begin
		find_hit = 1'b0;
		find_idx = '0;
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = MAX_TENANTS - 1; i >= 0; i--) begin
			if (t_valid_q[i] && t_crc_q[i] == crc_q && t_size_q[i] == size_q
				&& t_api_q[i] == api_q) begin
				find_hit = 1'b1;
				find_idx = TID_W'(i);
			end
			if (!t_valid_q[i]) begin
				free_hit = 1'b1;
				free_idx = TID_W'(i);
			end
		end
		unpin_hit = 1'b0;
		unpin_idx = '0;
		for (int j = MAX_PINS - 1; j >= 0; j--) begin
			if (PIN_CW'(j) < pin_count_q && pin_addr_q[j] == baddr_q
				&& pin_pages_q[j] == pcnt_q) begin
				unpin_hit = 1'b1;
				unpin_idx = PIN_IW'(j);
			end
		end
	end
	assign last_idx = PIN_IW'(pin_count_q - PIN_CW'(1));

	// status to the controller
	always_comb begin
		st.is_alloc = (op_q == OP_ALLOC);
		st.alloc_bad = (n_pages < PG_W'(2)) || (pcnt_q == '0)
			|| (pcnt_q > n_pages - PG_W'(1));
		st.scan_hit = !busy && (nrun == pcnt_q);
		st.scan_end = (p_q == n_pages - PG_W'(1));
		st.evict_last = (ev_idx_q == TID_W'(MAX_TENANTS - 1));
		st.have_victim = ev_have_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			shift_q <= 5'd12;
			total_q <= 9'd256;
		end else if (cfg_wr) begin
			if (cfg_index == CFG_REGION_BASE) begin
				base_q <= cfg_data;
			end
			if (cfg_index == CFG_PAGE_SHIFT) begin
				shift_q <= cfg_data[4:0];
			end
			if (cfg_index == CFG_NUM_PAGES) begin
				total_q <= cfg_data[PG_W-1:0];
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			slot_q <= slot;
			crc_q <= key_crc;
			size_q <= key_size;
			api_q <= key_api;
			baddr_q <= block_address;
			pcnt_q <= page_count;
			stin_q <= stamp_in;
		end
	end

	// directory updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_valid_q <= '0;
			stamp_next_q <= 32'd1;
			for (int i = 0; i < MAX_TENANTS; i++) begin
				t_crc_q[i] <= '0;
				t_size_q[i] <= '0;
				t_api_q[i] <= '0;
				t_addr_q[i] <= '0;
				t_pages_q[i] <= '0;
				t_stamp_q[i] <= '0;
			end
		end else begin
			if (cmd.exec && op_q == OP_TOUCH) begin
				t_stamp_q[slot_q] <= stamp_next_q;
				stamp_next_q <= stamp_next_q + 32'd1;
			end
			if (cmd.exec && op_q == OP_PUT && free_hit) begin
				t_valid_q[free_idx] <= 1'b1;
				t_crc_q[free_idx] <= crc_q;
				t_size_q[free_idx] <= size_q;
				t_api_q[free_idx] <= api_q;
				t_addr_q[free_idx] <= baddr_q;
				t_pages_q[free_idx] <= pcnt_q;
				t_stamp_q[free_idx] <= stin_q;
			end
			if (cmd.exec && op_q == OP_FORMAT) begin
				t_valid_q <= '0;
				stamp_next_q <= 32'd1;
				for (int i = 0; i < MAX_TENANTS; i++) begin
					t_crc_q[i] <= '0;
					t_size_q[i] <= '0;
					t_api_q[i] <= '0;
					t_addr_q[i] <= '0;
					t_pages_q[i] <= '0;
					t_stamp_q[i] <= '0;
				end
			end
			if (cmd.evict_apply && ev_have_q) begin
				t_valid_q[ev_victim_q] <= 1'b0;
			end
		end
	end

	// pin table count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_count_q <= '0;
		end else if (cmd.exec && op_q == OP_PIN && pcnt_q != '0
			&& pin_count_q < PIN_CW'(MAX_PINS)) begin
			pin_count_q <= pin_count_q + PIN_CW'(1);
		end else if (cmd.exec && op_q == OP_UNPIN && unpin_hit) begin
			pin_count_q <= pin_count_q - PIN_CW'(1);
		end
	end

	// pin table entries
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_PIN && pcnt_q != '0 && pin_count_q < PIN_CW'(MAX_PINS)) begin
			pin_addr_q[pin_count_q[PIN_IW-1:0]] <= baddr_q;
			pin_pages_q[pin_count_q[PIN_IW-1:0]] <= pcnt_q;
		end else if (cmd.exec && op_q == OP_UNPIN && unpin_hit) begin
			pin_addr_q[unpin_idx] <= pin_addr_q[last_idx];
			pin_pages_q[unpin_idx] <= pin_pages_q[last_idx];
		end
	end

	// page scan and victim scan
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			p_q <= PG_W'(1);
			run_q <= '0;
		end else if (cmd.scan_step) begin
			p_q <= p_q + PG_W'(1);
			run_q <= nrun;
		end
		if (cmd.evict_init) begin
			ev_idx_q <= '0;
			ev_have_q <= 1'b0;
		end else if (cmd.evict_step) begin
			ev_idx_q <= ev_idx_q + TID_W'(1);
			if (cand) begin
				ev_have_q <= 1'b1;
				ev_victim_q <= rd_idx;
				ev_best_q <= t_stamp_q[rd_idx];
			end
		end
	end

	// working result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= 1'b1;
			res_slot_q <= '0;
			res_addr_q <= '0;
			res_valid_q <= 1'b0;
			res_crc_q <= '0;
			res_size_q <= '0;
			res_api_q <= '0;
			res_pages_q <= '0;
			res_stamp_q <= '0;
			res_evc_q <= '0;
		end else if (cmd.exec) begin
			unique case (op_q)
				OP_FIND: begin
					res_status_q <= !find_hit;
					res_slot_q <= find_idx;
				end
				OP_TOUCH: begin
					res_status_q <= 1'b0;
				end
				OP_PUT: begin
					res_status_q <= !free_hit;
					res_slot_q <= free_idx;
				end
				OP_ALLOC: begin
					res_status_q <= 1'b1;
				end
				OP_PIN: begin
					res_status_q <= !(pcnt_q != '0 && pin_count_q < PIN_CW'(MAX_PINS));
				end
				OP_UNPIN: begin
					res_status_q <= !unpin_hit;
				end
				OP_READ: begin
					res_status_q <= 1'b0;
					res_addr_q <= t_addr_q[rd_idx];
					res_valid_q <= t_valid_q[rd_idx];
					res_crc_q <= t_crc_q[rd_idx];
					res_size_q <= t_size_q[rd_idx];
					res_api_q <= t_api_q[rd_idx];
					res_pages_q <= t_pages_q[rd_idx];
					res_stamp_q <= t_stamp_q[rd_idx];
				end
				OP_FORMAT: begin
					res_status_q <= 1'b0;
				end
				default: begin
					res_status_q <= 1'b1;
				end
			endcase
		end else if (cmd.fin_ok) begin
			res_status_q <= 1'b0;
			res_addr_q <= base_q + start_off;
		end else if (cmd.evict_apply && ev_have_q) begin
			res_evc_q <= res_evc_q + EVC_W'(1);
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q <= res_slot_q;
			out_addr_q <= res_addr_q;
			out_valid_q <= res_valid_q;
			out_crc_q <= res_crc_q;
			out_size_q <= res_size_q;
			out_api_q <= res_api_q;
			out_pages_q <= res_pages_q;
			out_stamp_q <= res_stamp_q;
			out_evc_q <= res_evc_q;
		end
	end

	assign status = out_status_q;
	assign found_slot = out_slot_q;
	assign alloc_address = out_addr_q;
	assign entry_valid = out_valid_q;
	assign entry_crc = out_crc_q;
	assign entry_size = out_size_q;
	assign entry_api = out_api_q;
	assign entry_pages = out_pages_q;
	assign entry_stamp = out_stamp_q;
	assign evicted_count = out_evc_q;

`ifndef SYNTHESIS
	a_pin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pin_count_q <= PIN_CW'(MAX_PINS))
		else $error("pin table overfilled");
	a_victim_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict_apply && ev_have_q |=> !t_valid_q[$past(ev_victim_q)])
		else $error("victim still valid after eviction");
	a_evict_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_ok |-> res_evc_q <= EVC_W'(MAX_TENANTS))
		else $error("more evictions than tenants");
`endif

endmodule

// ----- src/page_block_allocator_lru_evict.sv -----
// top level of the paged flash tenant directory with lru eviction
//
// Input channel in_valid/in_ready carries one request word (operation, slot,
// keys, block_address, page_count, stamp_in). Output channel out_valid/out_ready
// returns exactly one result word per request. Configuration writes go over
// cfg_valid/cfg_ready with cfg_index (0 region base, 1 page shift, 2 region page
// count) and cfg_data; cfg_ready is always high, writes to other indexes are dropped.
// Requests are handled one at a time. find, touch, put, pin, unpin, read and
// format pass the execute and done steps; out_valid rises when the done step
// loads the output register. alloc walks pages one per cycle from page 1 and,
// when no run fits, scans the 8 tenants one per cycle for the lru victim and
// drops it, then walks again until a run fits or no victim is left; an alloc
// with a bad page count skips the walk. The block is idle again, and can take
// the next request, in the same cycle that out_valid rises.
// in_ready is high only while no request is in work. A finished word waits in
// the output register; while it is not taken, the next finished word is held
// in the done step. Reset clears the directory and pin count, sets the stamp
// counter to 1 and the registers to their defaults (page shift 12, 256 pages).
module page_block_allocator_lru_evict (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [2:0]  slot,
	input  logic [31:0] key_crc,
	input  logic [31:0] key_size,
	input  logic [31:0] key_api,
	input  logic [31:0] block_address,
	input  logic [8:0]  page_count,
	input  logic [31:0] stamp_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [2:0]  found_slot,
	output logic [31:0] alloc_address,
	output logic        entry_valid,
	output logic [31:0] entry_crc,
	output logic [31:0] entry_size,
	output logic [31:0] entry_api,
	output logic [8:0]  entry_pages,
	output logic [31:0] entry_stamp,
	output logic [3:0]  evicted_count
);
	import pba_pkg::*;

	ctrl_cmd_t cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	// sequencer
	pba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath
	pba_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_wr        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.slot          (slot),
		.key_crc       (key_crc),
		.key_size      (key_size),
		.key_api       (key_api),
		.block_address (block_address),
		.page_count    (page_count),
		.stamp_in      (stamp_in),
		.status        (status),
		.found_slot    (found_slot),
		.alloc_address (alloc_address),
		.entry_valid   (entry_valid),
		.entry_crc     (entry_crc),
		.entry_size    (entry_size),
		.entry_api     (entry_api),
		.entry_pages   (entry_pages),
		.entry_stamp   (entry_stamp),
		.evicted_count (evicted_count)
	);

endmodule
